// ===== sv/cxs_pkg.sv =====
package cxs_pkg;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int DX_W = 21;
  localparam int FEED_W = 16;
  localparam int SLEN_W = 20;
  localparam int CFG_W = 20;
  localparam logic CFG_FEED = 1'b0;
  localparam logic CFG_SLEN = 1'b1;
  localparam int POS_W = 32;
  localparam int IV_W = 32;
  // squared length sum shifted by 16: (2*2^20)^2*2 << 16 < 2^60
  localparam int SQ_W = 60;
  localparam int LEN_W = 30;
  localparam int DIV_W = 64;
  localparam int CNT_W = 6;
endpackage

// ===== sv/corexy_step_pulse_timer_unit.sv =====
// Sequence: a tick goes from accept through S_TICK to the result beat; a load runs
// a square root, then five divisions on one shared shift/subtract unit stepping
// one quotient bit a cycle, then the result beat; the root has its own logic.
// Throughput: one item at a time; the next is taken once the result beat leaves.
// Reset: synchronous, active high; clears all move state and restores the
// default feed rate and step length.
module corexy_step_pulse_timer_unit
  import cxs_pkg::*;
#(
  parameter int TIME_WIDTH = 32,
  parameter int STEP_COUNT_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic signed [DX_W-1:0] delta_x_um,
  input  logic signed [DX_W-1:0] delta_y_um,
  output logic out_valid,
  input  logic out_ready,
  output logic step_a_level,
  output logic dir_a_neg,
  output logic step_b_level,
  output logic dir_b_neg,
  output logic signed [POS_W-1:0] pos_x_half,
  output logic signed [POS_W-1:0] pos_y_half,
  output logic [STEP_COUNT_WIDTH-1:0] steps_done_a,
  output logic [STEP_COUNT_WIDTH-1:0] steps_done_b,
  output logic move_done
);
  localparam logic [3:0] S_IDLE = 4'd0, S_TICK = 4'd1, S_SQRT = 4'd2, S_TIME = 4'd3,
                         S_STA = 4'd4, S_STB = 4'd5, S_IVA = 4'd6, S_IVB = 4'd7,
                         S_OUT = 4'd8;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;
  localparam logic [STEP_COUNT_WIDTH-1:0] SMAX = '1;
  localparam int SC = STEP_COUNT_WIDTH;

  logic [3:0] state;
  logic [FEED_W-1:0] feed_rate;
  logic [SLEN_W-1:0] step_length_nm;
  logic [IV_W-1:0] interval_a, interval_b, elapsed_a, elapsed_b;
  logic [SC-1:0] total_a, total_b, count_a, count_b;
  logic [1:0] sign_a, sign_b;
  logic level_a, level_b;
  logic [POS_W-1:0] pos_x, pos_y;
  logic signed [DX_W:0] mot_a, mot_b;
  logic [SQ_W-1:0] sq_v, sq_r;
  logic [CNT_W-1:0] cnt;
  // shared restoring divider: rem, quotient/dividend shift register, divisor
  logic [DIV_W-1:0] dv_rem, dv_q, dv_d;
  logic [DIV_W:0] dv_try;
  logic [DIV_W-1:0] time_v;
  logic [SC-1:0] st_a, st_b;
  logic [DIV_W-1:0] sq_bit, sq_try;
  logic [DX_W-1:0] ux, uy;
  logic [2*DX_W-1:0] ux2, uy2;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign step_a_level = level_a;
  assign step_b_level = level_b;
  assign dir_a_neg = (sign_a == 2'd3);
  assign dir_b_neg = (sign_b == 2'd3);
  assign pos_x_half = pos_x;
  assign pos_y_half = pos_y;
  assign steps_done_a = count_a;
  assign steps_done_b = count_b;
  assign move_done = (count_a >= total_a) && (count_b >= total_b);

  assign ux = delta_x_um[DX_W-1] ? DX_W'(-delta_x_um) : DX_W'(delta_x_um);
  assign uy = delta_y_um[DX_W-1] ? DX_W'(-delta_y_um) : DX_W'(delta_y_um);
  assign ux2 = ux * ux;
  assign uy2 = uy * uy;

  assign sq_bit = DIV_W'(1) << {cnt, 1'b0};
  assign sq_try = DIV_W'(sq_r) + sq_bit;
  assign dv_try = {dv_rem[DIV_W-2:0], dv_q[DIV_W-1]} - {1'b0, dv_d};

  function automatic logic [DIV_W-1:0] mag_of(input logic signed [DX_W:0] d);
    logic [DX_W:0] m;
    m = d[DX_W] ? (DX_W+1)'(-d) : (DX_W+1)'(d);
    return DIV_W'(m);
  endfunction
  function automatic logic [1:0] sgn_of(input logic signed [DX_W:0] d);
    return d[DX_W] ? 2'd3 : (d != '0 ? 2'd1 : 2'd0);
  endfunction

  logic [DIV_W-1:0] sl_eff, fd_eff;
  assign sl_eff = (step_length_nm == '0) ? DIV_W'(1) : DIV_W'(step_length_nm);
  assign fd_eff = (feed_rate == '0) ? DIV_W'(1) : DIV_W'(feed_rate);

  logic [DIV_W-1:0] stp_num_a, stp_num_b;
  assign stp_num_a = (mag_of(mot_a) * 64'd2000) + sl_eff;
  assign stp_num_b = (mag_of(mot_b) * 64'd2000) + sl_eff;

  logic [DIV_W-1:0] q_fin;
  assign q_fin = {dv_q[DIV_W-2:0], ~dv_try[DIV_W]};

  function automatic logic [SC-1:0] sat_st(input logic [DIV_W-1:0] q);
    return (q > DIV_W'(SMAX)) ? SMAX : SC'(q);
  endfunction

  logic step_a, step_b;
  logic [IV_W-1:0] ea_inc, eb_inc;
  assign ea_inc = (elapsed_a == '1) ? elapsed_a : elapsed_a + 1'b1;
  assign eb_inc = (elapsed_b == '1) ? elapsed_b : elapsed_b + 1'b1;
  assign step_a = (interval_a != '0) && (ea_inc > interval_a) && (count_a < total_a);
  assign step_b = (interval_b != '0) && (eb_inc > interval_b) && (count_b < total_b);
  logic [1:0] da, db;
  assign da = step_a ? sign_a : 2'd0;
  assign db = step_b ? sign_b : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      feed_rate <= FEED_W'(1200);
      step_length_nm <= SLEN_W'(172788);
      interval_a <= '0; interval_b <= '0; elapsed_a <= '0; elapsed_b <= '0;
      total_a <= '0; total_b <= '0; count_a <= '0; count_b <= '0;
      sign_a <= '0; sign_b <= '0; level_a <= 1'b0; level_b <= 1'b0;
      pos_x <= '0; pos_y <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FEED) feed_rate <= cfg_data[FEED_W-1:0];
        else step_length_nm <= cfg_data[SLEN_W-1:0];
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          if (command == CMD_TICK) state <= S_TICK;
          else begin
            mot_a <= (DX_W+1)'(delta_x_um) + (DX_W+1)'(delta_y_um);
            mot_b <= (DX_W+1)'(delta_x_um) - (DX_W+1)'(delta_y_um);
            sq_v <= SQ_W'({(2*DX_W+1)'(ux2) + (2*DX_W+1)'(uy2), 16'd0});
            sq_r <= '0;
            cnt <= CNT_W'(LEN_W - 1);
            state <= S_SQRT;
          end
        end
        S_TICK: begin
          elapsed_a <= step_a ? '0 : ea_inc;
          elapsed_b <= step_b ? '0 : eb_inc;
          if (step_a) begin level_a <= ~level_a; count_a <= count_a + 1'b1; end
          if (step_b) begin level_b <= ~level_b; count_b <= count_b + 1'b1; end
          // +1 / -1 per stepping motor: x gets dA+dB, y gets dA-dB
          pos_x <= pos_x + {{(POS_W-2){da[1]}}, da} + {{(POS_W-2){db[1]}}, db};
          pos_y <= pos_y + {{(POS_W-2){da[1]}}, da} - {{(POS_W-2){db[1]}}, db};
          state <= S_OUT;
        end
        S_SQRT: begin
          // one result bit per cycle, high bit first
          if (DIV_W'(sq_v) >= sq_try) begin
            sq_v <= SQ_W'(DIV_W'(sq_v) - sq_try);
            sq_r <= SQ_W'((DIV_W'(sq_r) >> 1) + sq_bit);
          end else sq_r <= sq_r >> 1;
          if (cnt == '0) state <= S_TIME;
          else cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            dv_rem <= '0; cnt <= '1;
            dv_d <= fd_eff << 8;
          end
        end
        default: ;
      endcase
      // dividend load for time after square root completes
      if (state == S_SQRT && cnt == '0)
        dv_q <= (DIV_W'((DIV_W'(sq_v) >= sq_try) ? ((DIV_W'(sq_r) >> 1) + sq_bit)
                                                 : (DIV_W'(sq_r) >> 1))) * 64'd60000;
      if (state == S_TIME || state == S_STA || state == S_STB ||
          state == S_IVA || state == S_IVB) begin
        dv_rem <= dv_try[DIV_W] ? {dv_rem[DIV_W-2:0], dv_q[DIV_W-1]} : dv_try[DIV_W-1:0];
        dv_q <= q_fin;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          dv_rem <= '0; cnt <= '1;
          unique case (state)
            S_TIME: begin
              time_v <= (q_fin > DIV_W'(TMAX)) ? DIV_W'(TMAX) : q_fin;
              dv_q <= stp_num_a; dv_d <= sl_eff << 1; state <= S_STA;
            end
            S_STA: begin
              st_a <= sat_st(q_fin);
              dv_q <= stp_num_b; dv_d <= sl_eff << 1; state <= S_STB;
            end
            S_STB: begin
              st_b <= sat_st(q_fin);
              dv_q <= time_v;
              dv_d <= (st_a == '0) ? DIV_W'(1) : DIV_W'(st_a);
              state <= S_IVA;
            end
            S_IVA: begin
              interval_a <= (st_a == '0) ? '0 :
                            ((q_fin > 64'hFFFF_FFFF) ? '1 : IV_W'(q_fin));
              dv_q <= time_v;
              dv_d <= (st_b == '0) ? DIV_W'(1) : DIV_W'(st_b);
              state <= S_IVB;
            end
            default: begin
              interval_b <= (st_b == '0) ? '0 :
                            ((q_fin > 64'hFFFF_FFFF) ? '1 : IV_W'(q_fin));
              total_a <= st_a; total_b <= st_b;
              sign_a <= sgn_of(mot_a); sign_b <= sgn_of(mot_b);
              count_a <= '0; count_b <= '0; elapsed_a <= '0; elapsed_b <= '0;
              state <= S_OUT;
            end
          endcase
        end
      end
      if (state == S_OUT && out_ready) state <= S_IDLE;
    end
  end

`ifndef SYNTH
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result held");
  a_tick_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_TICK) |=> ##1 out_valid)
    else $error("tick result late");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= total_a) && (count_b <= total_b)) else $error("count past total");
`endif
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cxs_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic sa;
    logic da;
    logic sb;
    logic db;
    logic [31:0] px;
    logic [31:0] py;
    logic [23:0] ca;
    logic [23:0] cb;
    logic done;
  } motion_t;

  typedef struct {
    logic cmd;
    int dx;
    int dy;
    bit fixed;
    motion_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = CFG_FEED;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic command = CMD_TICK;
  logic signed [DX_W-1:0] delta_x_um = '0;
  logic signed [DX_W-1:0] delta_y_um = '0;
  logic out_valid;
  logic out_ready = 0;
  logic step_a_level, dir_a_neg, step_b_level, dir_b_neg, move_done;
  logic signed [POS_W-1:0] pos_x_half, pos_y_half;
  logic [23:0] steps_done_a, steps_done_b;

  corexy_step_pulse_timer_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow copy of the motion state
  bit [31:0] feed, slen;
  bit [31:0] iv_a, iv_b, el_a, el_b, px, py;
  bit [23:0] tot_a, tot_b, cnt_a, cnt_b;
  bit [1:0] sg_a, sg_b;
  bit lv_a, lv_b;

  motion_t pending_motion[$];
  int errors = 0, beats_checked = 0, loads_sent = 0, ticks_sent = 0, cycles = 0;
  int idle_pct = 0, stall_pct = 0;

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r = 0;
    bit [63:0] b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void plan_axis(input longint d, input bit [63:0] tm,
                                    output bit [23:0] tot, output bit [31:0] iv,
                                    output bit [1:0] sg);
    bit [63:0] mag = d < 0 ? -d : d;
    bit [63:0] s = slen[19:0] != 0 ? 64'(slen[19:0]) : 64'd1;
    bit [63:0] n = (2 * mag * 1000 + s) / (2 * s);
    if (n > 64'hFFFFFF) n = 64'hFFFFFF;
    sg = d > 0 ? 2'd1 : (d < 0 ? 2'd3 : 2'd0);
    iv = n == 0 ? 32'd0 : 32'(tm / n);
    tot = n[23:0];
  endfunction

  function automatic int tick_axis(ref bit [31:0] el, input bit [31:0] iv,
                                   ref bit [23:0] cnt, input bit [23:0] tot,
                                   ref bit lv, input bit [1:0] sg);
    if (el != 32'hFFFFFFFF) el++;
    if (iv != 0 && el > iv && cnt < tot) begin
      lv = ~lv;
      cnt++;
      el = 0;
      return sg == 2'd1 ? 1 : (sg == 2'd3 ? -1 : 0);
    end
    return 0;
  endfunction

  function automatic motion_t advance_motion(logic cmd, int dx, int dy);
    motion_t m;
    longint ux, uy;
    bit [63:0] len, f, tm;
    int ma, mb;
    if (cmd == CMD_LOAD) begin
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      len = root_floor((ux * ux + uy * uy) << 16);
      f = feed[15:0] != 0 ? 64'(feed[15:0]) : 64'd1;
      tm = (len * 60000) / (f * 256);
      if (tm > 64'hFFFFFFFF) tm = 64'hFFFFFFFF;
      plan_axis(longint'(dx) + dy, tm, tot_a, iv_a, sg_a);
      plan_axis(longint'(dx) - dy, tm, tot_b, iv_b, sg_b);
      cnt_a = 0; cnt_b = 0; el_a = 0; el_b = 0;
    end else begin
      ma = tick_axis(el_a, iv_a, cnt_a, tot_a, lv_a, sg_a);
      mb = tick_axis(el_b, iv_b, cnt_b, tot_b, lv_b, sg_b);
      px += 32'(ma + mb);
      py += 32'(ma - mb);
    end
    m.sa = lv_a; m.da = sg_a == 2'd3; m.sb = lv_b; m.db = sg_b == 2'd3;
    m.px = px; m.py = py; m.ca = cnt_a; m.cb = cnt_b;
    m.done = cnt_a >= tot_a && cnt_b >= tot_b;
    return m;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %0h want %0h", beats_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    motion_t w;
    if (out_valid && out_ready) begin
      if (pending_motion.size() == 0) begin
        errors++;
        $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        w = pending_motion.pop_front();
        if (step_a_level !== w.sa) report("step_a_level", step_a_level, w.sa);
        if (dir_a_neg !== w.da) report("dir_a_neg", dir_a_neg, w.da);
        if (step_b_level !== w.sb) report("step_b_level", step_b_level, w.sb);
        if (dir_b_neg !== w.db) report("dir_b_neg", dir_b_neg, w.db);
        if (pos_x_half !== w.px) report("pos_x_half", pos_x_half, w.px);
        if (pos_y_half !== w.py) report("pos_y_half", pos_y_half, w.py);
        if (steps_done_a !== w.ca) report("steps_done_a", steps_done_a, w.ca);
        if (steps_done_b !== w.cb) report("steps_done_b", steps_done_b, w.cb);
        if (move_done !== w.done) report("move_done", move_done, w.done);
      end
      beats_checked++;
    end
    out_ready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(logic cmd, int dx, int dy, bit fixed = 0, motion_t want = '0);
    motion_t m;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    command <= cmd;
    delta_x_um <= dx[DX_W-1:0];
    delta_y_um <= dy[DX_W-1:0];
    do @(posedge clk); while (!in_ready);
    m = advance_motion(cmd, int'(signed'(dx[DX_W-1:0])), int'(signed'(dy[DX_W-1:0])));
    pending_motion.push_back(fixed ? want : m);
    if (cmd == CMD_LOAD) loads_sent++; else ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_FEED) feed = 32'(val[15:0]); else slen = 32'(val[19:0]);
    @(posedge clk);
  endtask

  task automatic random_moves(int budget, bit hold_once);
    int sent = 0, n, span;
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        span = $urandom_range(9) == 0 ? 1048575 : 20;
        send(CMD_LOAD, $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
        n = $urandom_range(120, 5);
        repeat (n) send(CMD_TICK, $urandom, $urandom);
        sent += n + 1;
      end else begin
        send($urandom_range(1), $urandom, $urandom);
        sent++;
      end
      if (hold_once && sent > budget / 2) begin
        hold_once = 0;
        in_valid <= 0;
        while (pending_motion.size() != 0) @(posedge clk);
      end
    end
  endtask

  row_t rows[$];
  motion_t z;

  initial begin
    feed = 1200; slen = 172788;
    repeat (3) @(posedge clk);
    rst <= 0;
    set_reg(CFG_FEED, 30000);
    set_reg(CFG_SLEN, 1000);

    z = '0; z.done = 1;
    rows.push_back('{CMD_TICK, 0, 0, 1, z});
    z = '0; z.da = 1;
    rows.push_back('{CMD_LOAD, -1048576, -1048576, 1, z});
    rows.push_back('{CMD_LOAD, 1048575, 1048575, 0, '0});
    rows.push_back('{CMD_LOAD, 1048575, -1048576, 0, '0});
    rows.push_back('{CMD_LOAD, 0, 0, 0, '0});
    rows.push_back('{CMD_TICK, 7, -9, 0, '0});
    rows.push_back('{CMD_LOAD, 5, -5, 0, '0});
    rows.push_back('{CMD_LOAD, 3, 0, 0, '0});
    repeat (8) rows.push_back('{CMD_TICK, -1, 1, 0, '0});
    rows.push_back('{CMD_LOAD, -2, 1, 0, '0});
    repeat (6) rows.push_back('{CMD_TICK, 0, 0, 0, '0});
    foreach (rows[i]) send(rows[i].cmd, rows[i].dx, rows[i].dy, rows[i].fixed, rows[i].want);
    drain();

    set_reg(CFG_FEED, 6000);
    random_moves(210, 1);
    drain();
    idle_pct = 81;
    set_reg(CFG_FEED, 65535);
    random_moves(210, 0);
    drain();
    idle_pct = 0; stall_pct = 81;
    set_reg(CFG_FEED, 0);
    set_reg(CFG_SLEN, 1048575);
    random_moves(210, 0);
    drain();
    idle_pct = 13; stall_pct = 13;
    set_reg(CFG_FEED, 12000);
    set_reg(CFG_SLEN, 2000);
    random_moves(210, 0);
    drain();

    if (pending_motion.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_motion.size());
    end
    $display("covered %0d loads and %0d ticks over five feed/step-length settings",
             loads_sent, ticks_sent);
    $display("%0d result beats checked, %0d mismatches", beats_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cxs_pkg.sv
sv/corexy_step_pulse_timer_unit.sv
test/testbench.sv
